[hw/rtl/offset_gravity_load_stiffness_assert.svh]
// assertion macros for the offset gravity load block
`ifndef OFFSET_GRAVITY_LOAD_STIFFNESS_ASSERT_SVH
`define OFFSET_GRAVITY_LOAD_STIFFNESS_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet while in reset
`define OGLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogls assertion failed");

// next-cycle implication
`define OGLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogls assertion failed");

`endif

[hw/rtl/ogls_pkg.sv]
// types, widths and rounding helper for the offset gravity load block
`default_nettype none
package ogls_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W = 66;    // rc and d operands
    localparam int WV_W = 64;    // weight vector, Q32.32
    localparam int PROD_W = OP_W + WV_W;
    localparam int SUM_W = PROD_W + 2;
    localparam int RES_W = 64;
    localparam int NUM_MUL = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASS   = 3'd0,
        REG_OFF_X  = 3'd1,
        REG_OFF_Y  = 3'd2,
        REG_OFF_Z  = 3'd3,
        REG_GRAV_X = 3'd4,
        REG_GRAV_Y = 3'd5,
        REG_GRAV_Z = 3'd6
    } ogls_reg_t;

    typedef struct packed {
        logic              kind;
        logic signed [31:0] rot_00;
        logic signed [31:0] rot_01;
        logic signed [31:0] rot_02;
        logic signed [31:0] rot_10;
        logic signed [31:0] rot_11;
        logic signed [31:0] rot_12;
        logic signed [31:0] rot_20;
        logic signed [31:0] rot_21;
        logic signed [31:0] rot_22;
    } ogls_item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] force_x;
        logic signed [RES_W-1:0] force_y;
        logic signed [RES_W-1:0] force_z;
        logic signed [RES_W-1:0] moment_x;
        logic signed [RES_W-1:0] moment_y;
        logic signed [RES_W-1:0] moment_z;
        logic signed [RES_W-1:0] stiff_xx;
        logic signed [RES_W-1:0] stiff_yy;
        logic signed [RES_W-1:0] stiff_zz;
        logic signed [RES_W-1:0] stiff_xy;
        logic signed [RES_W-1:0] stiff_xz;
        logic signed [RES_W-1:0] stiff_yz;
    } ogls_result_t;

    typedef struct packed {
        logic en_part;
        logic en_sum;
    } ogls_mul_ctrl_t;

    // round to nearest, ties up, from 46 or 47 fraction bits, then saturate
    function automatic logic signed [RES_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] v,
        input logic                    frac47
    );
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] r;
        logic                    ok;
        t = v + (frac47 ? (SUM_W'(1) <<< 46) : (SUM_W'(1) <<< 45));
        r = frac47 ? (t >>> 47) : (t >>> 46);
        ok = (r[SUM_W-1:RES_W-1] == {(SUM_W-RES_W+1){r[RES_W-1]}});
        if (ok)
            round_sat = r[RES_W-1:0];
        else if (t[SUM_W-1])
            round_sat = {1'b1, {(RES_W-1){1'b0}}};
        else
            round_sat = {1'b0, {(RES_W-1){1'b1}}};
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ogls_if.sv]
// item and result channel interfaces
`default_nettype none
interface ogls_item_if import ogls_pkg::*; ();
    logic       valid;
    logic       ready;
    ogls_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ogls_result_if import ogls_pkg::*; ();
    logic         valid;
    logic         ready;
    ogls_result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/ogls_mul.sv]
// two-stage 66 x 64 signed multiplier built from four 32-bit partial products
`default_nettype none
module ogls_mul import ogls_pkg::*; (
    input  wire logic                     clk,
    input  wire ogls_mul_ctrl_t           ctrl,
    input  wire logic signed [OP_W-1:0]   a,
    input  wire logic signed [WV_W-1:0]   b,
    output logic signed [PROD_W-1:0]      p
);

    logic signed [OP_W-33:0] ah;
    logic signed [32:0]      al;
    logic signed [31:0]      bh;
    logic signed [32:0]      bl;

    logic signed [OP_W-33+32:0] hh_reg;
    logic signed [OP_W-33+33:0] hl_reg;
    logic signed [64:0]         lh_reg;
    logic [63:0]                ll_reg;
    logic signed [PROD_W-1:0]   p_reg;

    assign ah = a[OP_W-1:32];
    assign al = $signed({1'b0, a[31:0]});
    assign bh = b[WV_W-1:32];
    assign bl = $signed({1'b0, b[31:0]});

    always_ff @(posedge clk)
    begin
        if (ctrl.en_part)
        begin
            hh_reg <= ah * bh;
            hl_reg <= ah * bl;
            lh_reg <= al * bh;
            ll_reg <= a[31:0] * b[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_sum)
        begin
            p_reg <= (PROD_W'(hh_reg) <<< 64) + (PROD_W'(hl_reg) <<< 32)
                   + (PROD_W'(lh_reg) <<< 32) + PROD_W'(ll_reg);
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

[hw/rtl/offset_gravity_load_stiffness.sv]
// top level of the offset gravity load and load stiffness pipeline
// Six-stage pipeline taking one transaction per clock unless stalled; a stalled
// result holds each full stage behind it up to the first empty one, and nothing
// is lost. Stage one forms the weight and the nine rotation products, stage two
// the rotated offset, stages three and four the fifteen wide products in four
// 32-bit partials each, stage five the cross and stiffness sums, stage six the
// rounding and saturation into the output register. Configuration is written
// through cfg_we/cfg_index/cfg_data, which the user must do only while no
// transaction is in flight; the block itself does not enforce this.
`default_nettype none
`include "offset_gravity_load_stiffness_assert.svh"
module offset_gravity_load_stiffness import ogls_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    ogls_item_if.sink                  item,
    ogls_result_if.source              result
);

    localparam int NST = 6;

    logic [31:0]        mass_reg;
    logic signed [31:0] off_reg [3];
    logic signed [31:0] grav_reg [3];

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] rdy;

    logic signed [31:0] rot [3][3];

    logic signed [63:0]     s1_p_reg [3][3];
    logic signed [WV_W-1:0] s1_w_reg [3];
    logic                   s1_kind_reg;

    logic signed [OP_W-1:0] s2_rc_reg [3];
    logic signed [OP_W-1:0] s2_d_reg [3];
    logic signed [WV_W-1:0] s2_w_reg [3];
    logic                   s2_kind_reg;

    logic signed [WV_W-1:0] s3_w_reg [3];
    logic                   s3_kind_reg;
    logic signed [WV_W-1:0] s4_w_reg [3];
    logic                   s4_kind_reg;

    logic signed [OP_W-1:0]   mul_a [NUM_MUL];
    logic signed [WV_W-1:0]   mul_b [NUM_MUL];
    logic signed [PROD_W-1:0] prod [NUM_MUL];
    ogls_mul_ctrl_t           mul_ctrl;

    logic signed [SUM_W-1:0] s5_m_reg [3];
    logic signed [SUM_W-1:0] s5_sd_reg [3];
    logic signed [SUM_W-1:0] s5_so_reg [3];
    logic signed [WV_W-1:0]  s5_w_reg [3];
    logic                    s5_kind_reg;

    ogls_result_t res_reg;
    logic         s6_kind_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i]  <= '0;
                grav_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASS:   mass_reg    <= cfg_data;
                REG_OFF_X:  off_reg[0]  <= cfg_data;
                REG_OFF_Y:  off_reg[1]  <= cfg_data;
                REG_OFF_Z:  off_reg[2]  <= cfg_data;
                REG_GRAV_X: grav_reg[0] <= cfg_data;
                REG_GRAV_Y: grav_reg[1] <= cfg_data;
                REG_GRAV_Z: grav_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // stall chain: a stage loads when empty or when the one after it moves
    always_comb
    begin
        rdy[NST-1] = !vld_reg[NST-1] || result.ready;
        for (int i = NST - 2; i >= 0; i--)
            rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= item.valid;
            for (int i = 1; i < NST; i++)
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign item.ready = rdy[0];

    assign rot[0][0] = item.data.rot_00;
    assign rot[0][1] = item.data.rot_01;
    assign rot[0][2] = item.data.rot_02;
    assign rot[1][0] = item.data.rot_10;
    assign rot[1][1] = item.data.rot_11;
    assign rot[1][2] = item.data.rot_12;
    assign rot[2][0] = item.data.rot_20;
    assign rot[2][1] = item.data.rot_21;
    assign rot[2][2] = item.data.rot_22;

    // stage 1: weight and rotation products
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_kind_reg <= item.data.kind;
            for (int i = 0; i < 3; i++)
            begin
                s1_w_reg[i] <= WV_W'($signed({1'b0, mass_reg}) * grav_reg[i]);
                for (int j = 0; j < 3; j++)
                    s1_p_reg[i][j] <= rot[i][j] * off_reg[j];
            end
        end
    end

    // stage 2: rotated offset, zero for the constant load so one path serves both
    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_kind_reg <= s1_kind_reg;
            for (int i = 0; i < 3; i++)
            begin
                logic signed [OP_W-1:0] rc;
                rc = s1_kind_reg ? (OP_W'(s1_p_reg[i][0]) + OP_W'(s1_p_reg[i][1])
                                    + OP_W'(s1_p_reg[i][2])) : '0;
                s2_rc_reg[i] <= rc;
                s2_d_reg[i]  <= (OP_W'(off_reg[i]) <<< 30) - rc;
                s2_w_reg[i]  <= s1_w_reg[i];
            end
        end
    end

    // cross product terms then the nine entries of rc w^T
    always_comb
    begin
        mul_a[0] = s2_d_reg[1]; mul_b[0] = s2_w_reg[2];
        mul_a[1] = s2_d_reg[2]; mul_b[1] = s2_w_reg[1];
        mul_a[2] = s2_d_reg[2]; mul_b[2] = s2_w_reg[0];
        mul_a[3] = s2_d_reg[0]; mul_b[3] = s2_w_reg[2];
        mul_a[4] = s2_d_reg[0]; mul_b[4] = s2_w_reg[1];
        mul_a[5] = s2_d_reg[1]; mul_b[5] = s2_w_reg[0];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                mul_a[6+3*i+j] = s2_rc_reg[i];
                mul_b[6+3*i+j] = s2_w_reg[j];
            end
    end

    assign mul_ctrl.en_part = rdy[2];
    assign mul_ctrl.en_sum  = rdy[3];

    for (genvar k = 0; k < NUM_MUL; k++)
    begin : g_mul
        ogls_mul u_mul (
            .clk  (clk),
            .ctrl (mul_ctrl),
            .a    (mul_a[k]),
            .b    (mul_b[k]),
            .p    (prod[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_w_reg    <= s2_w_reg;
        end
        if (rdy[3])
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_w_reg    <= s3_w_reg;
        end
    end

    // stage 5: moments and stiffness sums
    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s5_kind_reg  <= s4_kind_reg;
            s5_w_reg     <= s4_w_reg;
            s5_m_reg[0]  <= SUM_W'(prod[0]) - SUM_W'(prod[1]);
            s5_m_reg[1]  <= SUM_W'(prod[2]) - SUM_W'(prod[3]);
            s5_m_reg[2]  <= SUM_W'(prod[4]) - SUM_W'(prod[5]);
            s5_sd_reg[0] <= SUM_W'(prod[10]) + SUM_W'(prod[14]);
            s5_sd_reg[1] <= SUM_W'(prod[6]) + SUM_W'(prod[14]);
            s5_sd_reg[2] <= SUM_W'(prod[6]) + SUM_W'(prod[10]);
            s5_so_reg[0] <= -(SUM_W'(prod[7]) + SUM_W'(prod[9]));
            s5_so_reg[1] <= -(SUM_W'(prod[8]) + SUM_W'(prod[12]));
            s5_so_reg[2] <= -(SUM_W'(prod[11]) + SUM_W'(prod[13]));
        end
    end

    // stage 6: rounding and saturation
    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            s6_kind_reg      <= s5_kind_reg;
            res_reg.force_x  <= s5_kind_reg ? '0 : s5_w_reg[0];
            res_reg.force_y  <= s5_kind_reg ? '0 : s5_w_reg[1];
            res_reg.force_z  <= s5_kind_reg ? '0 : s5_w_reg[2];
            res_reg.moment_x <= round_sat(s5_m_reg[0], 1'b0);
            res_reg.moment_y <= round_sat(s5_m_reg[1], 1'b0);
            res_reg.moment_z <= round_sat(s5_m_reg[2], 1'b0);
            res_reg.stiff_xx <= round_sat(s5_sd_reg[0], 1'b0);
            res_reg.stiff_yy <= round_sat(s5_sd_reg[1], 1'b0);
            res_reg.stiff_zz <= round_sat(s5_sd_reg[2], 1'b0);
            res_reg.stiff_xy <= round_sat(s5_so_reg[0], 1'b1);
            res_reg.stiff_xz <= round_sat(s5_so_reg[1], 1'b1);
            res_reg.stiff_yz <= round_sat(s5_so_reg[2], 1'b1);
        end
    end

    assign result.valid = vld_reg[NST-1];
    assign result.data  = res_reg;

    `OGLS_ASSERT_IMP(a_full_stall, (&vld_reg) && !result.ready, !item.ready)
    `OGLS_ASSERT_NXT(a_take, item.valid && item.ready, vld_reg[0])
    `OGLS_ASSERT_IMP(a_kind1_force, result.valid && s6_kind_reg,
        res_reg.force_x == 0 && res_reg.force_y == 0 && res_reg.force_z == 0)
    `OGLS_ASSERT_IMP(a_kind0_stiff, result.valid && !s6_kind_reg,
        res_reg.stiff_xx == 0 && res_reg.stiff_yy == 0 && res_reg.stiff_zz == 0 &&
        res_reg.stiff_xy == 0 && res_reg.stiff_xz == 0 && res_reg.stiff_yz == 0)

endmodule
`default_nettype wire

[tb/offset_gravity_load_stiffness_tb.sv]
// self-checking testbench for the offset gravity load and load stiffness pipeline
`default_nettype none
module offset_gravity_load_stiffness_tb;
    import ogls_pkg::*;

    typedef logic signed [191:0] wide_t;
    typedef wide_t vec3_t [3];

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ogls_item_if item ();
    ogls_result_if result ();

    offset_gravity_load_stiffness dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item.sink),
        .result    (result.source)
    );

    always #1 clk = ~clk;

    // shadow copy of the configuration registers
    logic [31:0]        mass_q16;
    logic signed [31:0] offset_q16 [3];
    logic signed [31:0] gravity_q16 [3];

    ogls_result_t pending_loads [$];
    int  failures = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_request = 0;
    int  hold_left = 0;

    initial
    begin
        item.valid = 1'b0;
        item.data = '0;
        result.ready = 1'b0;
    end

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t r;
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
        return r;
    endfunction

    // round to nearest with ties upward, then clamp to 64 bits
    function automatic logic [RES_W-1:0] round_q32(wide_t v, int unsigned frac);
        wide_t t;
        wide_t r;
        t = v + (wide_t'(1) <<< (frac - 1));
        r = t >>> frac;
        if (r == {{128{r[63]}}, r[63:0]})
            return r[63:0];
        return t[191] ? SAT_MIN : SAT_MAX;
    endfunction

    function automatic ogls_result_t predict_load(ogls_item_t it);
        vec3_t w;
        vec3_t c;
        vec3_t rc;
        vec3_t d;
        vec3_t m;
        wide_t ab [3][3];
        logic signed [31:0] rot [9];
        ogls_result_t res;
        res = '0;
        rot = '{it.rot_00, it.rot_01, it.rot_02, it.rot_10, it.rot_11, it.rot_12,
                it.rot_20, it.rot_21, it.rot_22};
        for (int i = 0; i < 3; i++)
        begin
            w[i] = $signed({1'b0, mass_q16}) * gravity_q16[i];
            c[i] = offset_q16[i];
        end
        if (it.kind == 1'b0)
        begin
            m = cross3(c, w);
            res.force_x = w[0][63:0];
            res.force_y = w[1][63:0];
            res.force_z = w[2][63:0];
            res.moment_x = round_q32(m[0], 16);
            res.moment_y = round_q32(m[1], 16);
            res.moment_z = round_q32(m[2], 16);
            return res;
        end
        for (int i = 0; i < 3; i++)
        begin
            rc[i] = '0;
            for (int j = 0; j < 3; j++)
                rc[i] = rc[i] + rot[3 * i + j] * c[j];
            d[i] = (c[i] <<< 30) - rc[i];
        end
        m = cross3(d, w);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                ab[i][j] = rc[i] * w[j];
        res.moment_x = round_q32(m[0], 46);
        res.moment_y = round_q32(m[1], 46);
        res.moment_z = round_q32(m[2], 46);
        res.stiff_xx = round_q32(ab[1][1] + ab[2][2], 46);
        res.stiff_yy = round_q32(ab[0][0] + ab[2][2], 46);
        res.stiff_zz = round_q32(ab[0][0] + ab[1][1], 46);
        res.stiff_xy = round_q32(-(ab[0][1] + ab[1][0]), 47);
        res.stiff_xz = round_q32(-(ab[0][2] + ab[2][0]), 47);
        res.stiff_yz = round_q32(-(ab[1][2] + ab[2][1]), 47);
        return res;
    endfunction

    // waits for the pipeline to empty, then writes all registers plus the unused index
    task automatic load_config(logic [31:0] mass, logic [31:0] ox, logic [31:0] oy,
                               logic [31:0] oz, logic [31:0] gx, logic [31:0] gy,
                               logic [31:0] gz);
        logic [31:0] vals [7];
        vals = '{mass, ox, oy, oz, gx, gy, gz};
        item.valid <= 1'b0;
        while (pending_loads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= ogls_reg_t'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        // a write to the unused index must change nothing
        cfg_index <= REG_UNUSED;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        mass_q16 = mass;
        offset_q16 = '{ox, oy, oz};
        gravity_q16 = '{gx, gy, gz};
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            2: return 32'sd0 - 32'($urandom_range(0, 1 << 18));
            default: return 32'($urandom_range(0, 1 << 18));
        endcase
    endfunction

    task automatic random_config();
        load_config($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 1 << 20)),
                    rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
    endtask

    function automatic logic [31:0] rand_rot_entry(bit full);
        if (full)
            return $urandom;
        return 32'($signed(32'($urandom_range(0, 1 << 31))) - (1 <<< 30));
    endfunction

    function automatic ogls_item_t rand_item();
        ogls_item_t it;
        bit full;
        full = ($urandom_range(0, 3) == 0);
        it.kind = 1'($urandom_range(0, 1));
        it.rot_00 = rand_rot_entry(full);
        it.rot_01 = rand_rot_entry(full);
        it.rot_02 = rand_rot_entry(full);
        it.rot_10 = rand_rot_entry(full);
        it.rot_11 = rand_rot_entry(full);
        it.rot_12 = rand_rot_entry(full);
        it.rot_20 = rand_rot_entry(full);
        it.rot_21 = rand_rot_entry(full);
        it.rot_22 = rand_rot_entry(full);
        return it;
    endfunction

    // valid stays high after acceptance; it is only lowered when a gap follows
    task automatic send_item(ogls_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            item.data <= {$urandom_range(0, 1) == 1, {9{$urandom}}};
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.data <= it;
        do
            @(posedge clk);
        while (!item.ready);
        pending_loads.push_back(predict_load(it));
    endtask

    task automatic stop_sending();
        item.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic ogls_item_t make_item(logic kind, logic [31:0] r [9]);
        ogls_item_t it;
        it = {kind, r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};
        return it;
    endfunction

    task automatic test_reset_config();
        logic [31:0] r [9];
        r = '{default: 32'h4000_0000};
        mass_q16 = '0;
        offset_q16 = '{default: '0};
        gravity_q16 = '{default: '0};
        send_item(make_item(1'b0, r));
        send_item(make_item(1'b1, r));
        stop_sending();
    endtask

    task automatic test_directed();
        logic [31:0] ident [9];
        logic [31:0] rmin [9];
        logic [31:0] rmax [9];
        logic [31:0] rmix [9];
        ident = '{32'h4000_0000, 0, 0, 0, 32'h4000_0000, 0, 0, 0, 32'h4000_0000};
        rmin = '{default: 32'h8000_0000};
        rmax = '{default: 32'h7fff_ffff};
        rmix = '{32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff,
                 32'hffff_ffff, 1, 32'h3fff_ffff, 32'hc000_0000};
        // modest values: identity rotation gives a zero correction
        load_config(32'h0002_0000, 32'h0001_0000, 32'hffff_8000, 32'h0000_4000,
                    32'h0000_0000, 32'h0000_0000, 32'hfff6_3000);
        send_item(make_item(1'b0, ident));
        send_item(make_item(1'b1, ident));
        send_item(make_item(1'b1, rmix));
        // non-orthogonal matrix used unchanged
        send_item(make_item(1'b1, rmax));
        send_item(make_item(1'b1, rmin));
        // extremes everywhere so moments and stiffness saturate
        load_config(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_item(make_item(1'b0, rmin));
        send_item(make_item(1'b1, rmin));
        send_item(make_item(1'b1, rmax));
        send_item(make_item(1'b1, rmix));
        send_item(make_item(1'b1, ident));
        load_config(32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(make_item(1'b0, rmax));
        send_item(make_item(1'b1, rmax));
        send_item(make_item(1'b1, rmin));
        send_item(make_item(1'b1, rmix));
        // zero mass, large offset
        load_config(32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
                    32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff);
        send_item(make_item(1'b0, rmix));
        send_item(make_item(1'b1, rmix));
        stop_sending();
    endtask

    task automatic test_random(int s_pct, int r_pct, int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 75 == 0)
            begin
                stop_sending();
                random_config();
            end
            send_item(rand_item());
        end
        stop_sending();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
            send_item(rand_item());
        stop_sending();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        for (int i = 0; i < 10; i++)
            send_item(rand_item());
        stop_sending();
        while (pending_loads.size() != 0)
            @(posedge clk);
        for (int i = 0; i < 10; i++)
            send_item(rand_item());
        stop_sending();
    endtask

    // receiver readiness, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        logic [11:0][RES_W-1:0] got;
        logic [11:0][RES_W-1:0] want;
        string names [12];
        names = '{"stiff_yz", "stiff_xz", "stiff_xy", "stiff_zz", "stiff_yy", "stiff_xx",
                  "moment_z", "moment_y", "moment_x", "force_z", "force_y", "force_x"};
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_loads.size() == 0)
            begin
                $display("%0t: result transaction with nothing expected", $time);
                failures++;
            end
            else
            begin
                got = result.data;
                want = pending_loads.pop_front();
                for (int i = 0; i < 12; i++)
                    if (got[i] !== want[i])
                    begin
                        $display("%0t: %s expected %h actual %h", $time, names[i],
                                 want[i], got[i]);
                        failures++;
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_config();
        test_directed();
        test_random(24, 88, 425);
        test_random(88, 24, 425);
        test_random(0, 0, 425);
        test_backpressure();
        test_drain_pause();
        while (pending_loads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/ogls_pkg.sv
hw/rtl/ogls_if.sv
hw/rtl/ogls_mul.sv
hw/rtl/offset_gravity_load_stiffness.sv
tb/offset_gravity_load_stiffness_tb.sv
